// ----- sv/open_addressing_key_counter_assert.svh -----
// assertion macros for the open addressing key counter checker
// no dependencies; expects clk and rst in the scope of use
`ifndef OPEN_ADDRESSING_KEY_COUNTER_ASSERT_SVH
`define OPEN_ADDRESSING_KEY_COUNTER_ASSERT_SVH

// same-cycle implication, idle in reset
`define OAKC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, idle in reset
`define OAKC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/oakc_pkg.sv -----
// shared constants for the open addressing key counter
// no dependencies
package oakc_pkg;
  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int MAX_CHARS_DEF   = 8;
  localparam int CFG_W           = 11;
  localparam int LEN_W           = 4;
  localparam int HASH_W          = 32;
  localparam int HASH_MUL        = 31;
  localparam int COUNT_W         = 32;
  localparam int PROBE_W         = 10;
  localparam int DIV_BITS        = 4;
  localparam int DIV_STEPS       = HASH_W / DIV_BITS;
  localparam logic [CFG_W-1:0] TABLE_SIZE_RST = 11'd1021;
  // register indexes
  localparam logic REG_TABLE_SIZE = 1'b0;
  localparam logic REG_PROBE_MODE = 1'b1;
endpackage

// ----- sv/oakc_ram.sv -----
// generic single write port ram with registered read
// no dependencies
module oakc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- sv/oakc_front.sv -----
// front end: takes a key, hashes it and reduces the hash to home slot and step
// depends on oakc_pkg
module oakc_front import oakc_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int MAX_CHARS   = MAX_CHARS_DEF,
  localparam int KW = 8 * MAX_CHARS,
  localparam int SW = $clog2(TABLE_DEPTH + 1),
  localparam int IW = $clog2(TABLE_DEPTH),
  localparam int JW = KW + LEN_W + 2 * IW + SW
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             ready,
  input  logic [KW-1:0]    key_chars,
  input  logic [LEN_W-1:0] key_length,
  input  logic [CFG_W-1:0] table_size,
  input  logic             probe_mode,
  output logic             job_valid,
  input  logic             job_ready,
  output logic [JW-1:0]    job_data
);
  localparam int XW  = (SW > CFG_W) ? SW : CFG_W;
  localparam int DCW = $clog2(DIV_STEPS);
  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_HASH = 2'd1;
  localparam logic [1:0] F_DIV  = 2'd2;
  localparam logic [1:0] F_PUSH = 2'd3;

  logic [1:0]       state;
  logic [KW-1:0]    key_m, key_sh;
  logic [LEN_W-1:0] len, left;
  logic [HASH_W-1:0] hash, dvd;
  logic [SW-1:0]    ra, rb, size;
  logic             mode;
  logic [DCW-1:0]   cnt;

  logic [LEN_W-1:0] len_c;
  logic [KW-1:0]    key_mc;
  logic [XW-1:0]    size_x;
  logic [SW-1:0]    ra_next, rb_next, size_m1;
  logic [SW:0]      ta, tb;

  // clamp length and drop bytes past it, clamp table size to 2..TABLE_DEPTH
  always_comb begin
    len_c = (key_length > LEN_W'(MAX_CHARS)) ? LEN_W'(MAX_CHARS) : key_length;
    for (int b = 0; b < MAX_CHARS; b++) begin
      key_mc[b*8 +: 8] = (LEN_W'(b) < len_c) ? key_chars[b*8 +: 8] : 8'h00;
    end
    size_x = XW'(table_size);
    if (size_x < XW'(2)) begin
      size_x = XW'(2);
    end else if (size_x > XW'(TABLE_DEPTH)) begin
      size_x = XW'(TABLE_DEPTH);
    end
  end

  // restoring division, four quotient bits a cycle, remainders only
  always_comb begin
    size_m1 = size - SW'(1);
    ra_next = ra;
    rb_next = rb;
    ta = '0;
    tb = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      ta = {ra_next, dvd[HASH_W-1-i]};
      tb = {rb_next, dvd[HASH_W-1-i]};
      if (ta >= {1'b0, size}) begin
        ta = ta - {1'b0, size};
      end
      if (tb >= {1'b0, size_m1}) begin
        tb = tb - {1'b0, size_m1};
      end
      ra_next = ta[SW-1:0];
      rb_next = tb[SW-1:0];
    end
  end

  assign ready     = (state == F_IDLE);
  assign job_valid = (state == F_PUSH);
  assign job_data  = {key_m, len, IW'(ra), mode ? IW'(rb) + IW'(1) : IW'(1), size};

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (push) begin
            key_m  <= key_mc;
            key_sh <= key_mc;
            len    <= len_c;
            left   <= len_c;
            hash   <= '0;
            size   <= SW'(size_x);
            mode   <= probe_mode;
            state  <= F_HASH;
          end
        end
        F_HASH: begin
          if (left == '0) begin
            dvd   <= hash;
            ra    <= '0;
            rb    <= '0;
            cnt   <= '0;
            state <= F_DIV;
          end else begin
            hash   <= hash * HASH_W'(HASH_MUL) + HASH_W'(key_sh[7:0]);
            key_sh <= key_sh >> 8;
            left   <= left - LEN_W'(1);
          end
        end
        F_DIV: begin
          ra  <= ra_next;
          rb  <= rb_next;
          dvd <= dvd << DIV_BITS;
          cnt <= cnt + DCW'(1);
          if (cnt == DCW'(DIV_STEPS - 1)) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (job_ready) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end
endmodule

// ----- sv/oakc_queue.sv -----
// two entry job queue between front and back end
// depends on oakc_pkg
module oakc_queue import oakc_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_pop,
  output logic [WIDTH-1:0] out_data
);
  logic [WIDTH-1:0] entry [2];
  logic             wptr, rptr;
  logic [1:0]       fill;
  logic             do_push, do_pop;

  assign in_ready  = (fill != 2'd2);
  assign out_valid = (fill != 2'd0);
  assign out_data  = entry[rptr];
  assign do_push   = in_valid && in_ready;
  assign do_pop    = out_pop && out_valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wptr] <= in_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (do_push) begin
        wptr <= ~wptr;
      end
      if (do_pop) begin
        rptr <= ~rptr;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 2'd1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 2'd1;
      end
    end
  end
endmodule

// ----- sv/oakc_back.sv -----
// back end: clears the table after reset, then probes slots for each job
// depends on oakc_pkg and oakc_ram
module oakc_back import oakc_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int MAX_CHARS   = MAX_CHARS_DEF,
  localparam int KW = 8 * MAX_CHARS,
  localparam int SW = $clog2(TABLE_DEPTH + 1),
  localparam int IW = $clog2(TABLE_DEPTH),
  localparam int JW = KW + LEN_W + 2 * IW + SW
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  output logic               job_pop,
  input  logic [JW-1:0]      job_data,
  output logic               clearing,
  output logic               empty,
  input  logic               pop,
  output logic [COUNT_W-1:0] occurrences,
  output logic [PROBE_W-1:0] probe_count,
  output logic               first_seen,
  output logic               table_full
);
  localparam int RW = 1 + LEN_W + KW + COUNT_W;
  localparam int MW = (SW > PROBE_W) ? SW : PROBE_W;
  localparam logic [1:0] B_CLR   = 2'd0;
  localparam logic [1:0] B_IDLE  = 2'd1;
  localparam logic [1:0] B_PROBE = 2'd2;

  logic [1:0]       state;
  logic [IW-1:0]    idx, home, step;
  logic [SW-1:0]    size, moves;
  logic [KW-1:0]    key;
  logic [LEN_W-1:0] len;
  logic             res_valid;

  logic [KW-1:0]    j_key;
  logic [LEN_W-1:0] j_len;
  logic [IW-1:0]    j_home, j_step;
  logic [SW-1:0]    j_size;

  logic             we;
  logic [IW-1:0]    raddr;
  logic [RW-1:0]    wdata, rdata;
  logic             rd_valid, hit;
  logic [LEN_W-1:0] rd_len;
  logic [KW-1:0]    rd_key;
  logic [COUNT_W-1:0] rd_count, cnt_inc;
  logic [SW:0]      sum, nidx_w;
  logic [IW-1:0]    nidx;
  logic             wrap;

  assign {j_key, j_len, j_home, j_step, j_size} = job_data;
  assign rd_valid = rdata[RW-1];
  assign rd_len   = rdata[RW-2 -: LEN_W];
  assign rd_key   = rdata[COUNT_W +: KW];
  assign rd_count = rdata[COUNT_W-1:0];
  assign hit      = (rd_len == len) && (rd_key == key);
  assign cnt_inc  = (rd_count == '1) ? rd_count : rd_count + COUNT_W'(1);

  // next probe slot, sum stays below twice the size
  always_comb begin
    sum    = (SW+1)'(idx) + (SW+1)'(step);
    nidx_w = (sum >= (SW+1)'(size)) ? sum - (SW+1)'(size) : sum;
    nidx   = IW'(nidx_w);
    wrap   = (nidx == home) || (moves >= size - SW'(1));
  end

  // ram port control
  always_comb begin
    we      = 1'b0;
    wdata   = '0;
    raddr   = idx;
    job_pop = 1'b0;
    unique case (state)
      B_CLR: begin
        we = 1'b1;
      end
      B_IDLE: begin
        raddr   = j_home;
        job_pop = job_valid && !res_valid;
      end
      B_PROBE: begin
        if (!rd_valid) begin
          we    = 1'b1;
          wdata = {1'b1, len, key, COUNT_W'(1)};
        end else if (hit) begin
          we    = 1'b1;
          wdata = {1'b1, len, key, cnt_inc};
        end else begin
          raddr = nidx;
        end
      end
      default: ;
    endcase
  end

  oakc_ram #(
    .WIDTH (RW),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (idx),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign clearing = (state == B_CLR);
  assign empty    = !res_valid;

  // probe sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLR;
      idx       <= '0;
      res_valid <= 1'b0;
    end else begin
      if (pop && res_valid) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        B_CLR: begin
          idx <= idx + IW'(1);
          if (idx == IW'(TABLE_DEPTH - 1)) begin
            state <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (job_valid && !res_valid) begin
            key   <= j_key;
            len   <= j_len;
            idx   <= j_home;
            home  <= j_home;
            step  <= j_step;
            size  <= j_size;
            moves <= '0;
            state <= B_PROBE;
          end
        end
        B_PROBE: begin
          probe_count <= (MW'(moves) > MW'({PROBE_W{1'b1}})) ? '1 : PROBE_W'(moves);
          if (!rd_valid || hit || wrap) begin
            res_valid   <= 1'b1;
            state       <= B_IDLE;
            first_seen  <= !rd_valid;
            table_full  <= rd_valid && !hit;
            occurrences <= !rd_valid ? COUNT_W'(1) : (hit ? cnt_inc : '0);
          end else begin
            idx   <= nidx;
            moves <= moves + SW'(1);
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end
endmodule

// ----- sv/open_addressing_key_counter.sv -----
// Key counter over an open-addressing hash table with linear or double-hash
// probing. After reset the table is swept clear, one slot a cycle, with full
// held high. The front end then takes a new key only once it is done with
// the last, with key_length clamped to MAX_CHARS (an accept state, one hash
// byte a cycle, both remainders four bits a cycle, then a hand-over state that
// waits while the queue is full), and passes it through a two-entry queue to
// the back end, which starts a job once its result register is empty and then
// probes one slot a cycle through the single table ram read port.
// Front and back overlap, so steady state runs at the slower of the two.
// Configuration writes land at once and must happen while idle.
// depends on oakc_pkg, oakc_front, oakc_queue, oakc_back
module open_addressing_key_counter import oakc_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int MAX_CHARS   = MAX_CHARS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  logic [8*MAX_CHARS-1:0] key_chars,
  input  logic [LEN_W-1:0]       key_length,
  output logic                   empty,
  input  logic                   pop,
  output logic [COUNT_W-1:0]     occurrences,
  output logic [PROBE_W-1:0]     probe_count,
  output logic                   first_seen,
  output logic                   table_full,
  input  logic                   wr_en,
  input  logic                   wr_index,
  input  logic [CFG_W-1:0]       wr_data
);
  localparam int KW = 8 * MAX_CHARS;
  localparam int SW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int JW = KW + LEN_W + 2 * IW + SW;

  logic [CFG_W-1:0] table_size;
  logic             probe_mode;
  logic             front_ready, clearing;
  logic             fj_valid, fj_ready, bj_valid, bj_pop;
  logic [JW-1:0]    fj_data, bj_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= TABLE_SIZE_RST;
      probe_mode <= 1'b0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_TABLE_SIZE: table_size <= wr_data;
        REG_PROBE_MODE: probe_mode <= wr_data[0];
        default: ;
      endcase
    end
  end

  assign full = !front_ready || clearing;

  oakc_front #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .MAX_CHARS   (MAX_CHARS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push && !full),
    .ready      (front_ready),
    .key_chars  (key_chars),
    .key_length (key_length),
    .table_size (table_size),
    .probe_mode (probe_mode),
    .job_valid  (fj_valid),
    .job_ready  (fj_ready),
    .job_data   (fj_data)
  );

  oakc_queue #(
    .WIDTH (JW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fj_valid),
    .in_ready  (fj_ready),
    .in_data   (fj_data),
    .out_valid (bj_valid),
    .out_pop   (bj_pop),
    .out_data  (bj_data)
  );

  oakc_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .MAX_CHARS   (MAX_CHARS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (bj_valid),
    .job_pop     (bj_pop),
    .job_data    (bj_data),
    .clearing    (clearing),
    .empty       (empty),
    .pop         (pop),
    .occurrences (occurrences),
    .probe_count (probe_count),
    .first_seen  (first_seen),
    .table_full  (table_full)
  );
endmodule

// ----- sv/oakc_checker.sv -----
// port-level checks on result beats of the key counter, bound to the top level
// depends on oakc_pkg and open_addressing_key_counter_assert.svh
`include "open_addressing_key_counter_assert.svh"

module oakc_checker import oakc_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               empty,
  input logic               pop,
  input logic [COUNT_W-1:0] occurrences,
  input logic               first_seen,
  input logic               table_full
);
  // a waiting beat holds until taken
  `OAKC_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(occurrences), "result beat changed while waiting")
  // a full result carries no count
  `OAKC_ASSERT_NOW(a_full, !empty && table_full, occurrences == '0 && !first_seen, "full result with count")
  // a new key starts at one
  `OAKC_ASSERT_NOW(a_new, !empty && first_seen, occurrences == COUNT_W'(1) && !table_full, "new key count not one")
  // a found or stored key never reports zero
  `OAKC_ASSERT_NOW(a_nz, !empty && !table_full, occurrences != '0, "zero count without full")
endmodule

bind open_addressing_key_counter oakc_checker u_oakc_checker (.*);
